/* rtl/rict_pkg.sv */
package rict_pkg;

    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 8;
    localparam int CFG_W   = 64;
    localparam int INDEX_W = 2;

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    // "01234567" and "89abcdef", digit i in byte i
    localparam logic [CFG_W-1:0] CHARS_LOW_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0] CHARS_HIGH_RESET = 64'h6665_6463_6261_3938;

    typedef enum logic [INDEX_W-1:0] {
        REG_RADIX      = 2'd0,
        REG_CHARS_LOW  = 2'd1,
        REG_CHARS_HIGH = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_WAIT,
        ST_READ
    } state_t;

    // conversion link: one bit of the value moving up the chain
    typedef struct packed {
        logic valid;
        logic carry;
    } conv_link_t;

    // readout link: one digit moving up the chain
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               sig;
    } rd_link_t;

    function automatic logic [CHAR_W-1:0] digit_char(
        input logic [CFG_W-1:0]   chars_low,
        input logic [CFG_W-1:0]   chars_high,
        input logic [DIGIT_W-1:0] digit
    );
        logic [2*CFG_W-1:0] chars;
        chars = {chars_high, chars_low};
        return chars[8*digit +: CHAR_W];
    endfunction

endpackage

/* rtl/radix_integer_to_ascii.sv */
// Integer to text in a configurable radix (2..16).
// Input channel s_*: one transaction carries a value and a signed flag.
// Output channel m_*: one transaction per character, most significant first,
// an optional leading '-', m_last set on the final digit.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 radix,
// 1 digit chars 0..7, 2 digit chars 8..15); write only while idle.
// Operation: a row of VALUE_WIDTH digit cells converts the magnitude by
// doubling; value bits enter one per cycle and ripple up the row one cell
// per cycle. The digits are then shifted out of the top cell one per cycle
// unless the receiver stalls, leading zeros dropped; the next item is
// accepted once the last character sits in the output register.
// Reset: registers return to radix 10 and "0123456789abcdef", block idle.
// A stalled receiver holds the output register and pauses the readout; the
// chain keeps its digits until the receiver takes them.
module radix_integer_to_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [rict_pkg::INDEX_W-1:0]    cfg_index,
    input  logic [rict_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [31:0]                     s_value,
    input  logic                            s_is_signed,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rict_pkg::CHAR_W-1:0]     m_character,
    output logic                            m_last
);

    localparam int CW = $clog2(VALUE_WIDTH);

    logic [rict_pkg::RADIX_W-1:0] radix_reg;
    logic [rict_pkg::CFG_W-1:0]   chars_low_reg;
    logic [rict_pkg::CFG_W-1:0]   chars_high_reg;
    logic [rict_pkg::RADIX_W-1:0] radix_eff;

    rict_pkg::state_t state_reg;
    rict_pkg::state_t state_next;

    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [VALUE_WIDTH-1:0] mag_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [CW-1:0]          feed_cnt_reg;
    logic [CW-1:0]          feed_cnt_next;
    logic [CW-1:0]          rd_cnt_reg;
    logic [CW-1:0]          rd_cnt_next;

    logic [VALUE_WIDTH+31:0] value_ext;
    logic [VALUE_WIDTH-1:0]  value_in;
    logic                    neg_in;
    logic [VALUE_WIDTH-1:0]  mag_in;

    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [rict_pkg::CHAR_W-1:0] m_character_reg;
    logic                        m_last_reg;
    logic                        slot_free;
    logic                        load;
    logic [rict_pkg::CHAR_W-1:0] out_char;
    logic                        out_last;
    logic                        clear;
    logic                        shift;
    logic                        conv_done;
    logic                        emit;

    rict_pkg::conv_link_t conv_chain [0:VALUE_WIDTH];
    rict_pkg::rd_link_t   rd_chain   [0:VALUE_WIDTH];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg      <= rict_pkg::RADIX_RESET;
            chars_low_reg  <= rict_pkg::CHARS_LOW_RESET;
            chars_high_reg <= rict_pkg::CHARS_HIGH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rict_pkg::REG_RADIX:
                    radix_reg <= cfg_data[rict_pkg::RADIX_W-1:0];
                rict_pkg::REG_CHARS_LOW:  chars_low_reg  <= cfg_data;
                rict_pkg::REG_CHARS_HIGH: chars_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (radix_reg < rict_pkg::RADIX_MIN) begin
            radix_eff = rict_pkg::RADIX_MIN;
        end else if (radix_reg > rict_pkg::RADIX_MAX) begin
            radix_eff = rict_pkg::RADIX_MAX;
        end else begin
            radix_eff = radix_reg;
        end
    end

    // input value at the configured width, magnitude taken up front
    assign value_ext = {{VALUE_WIDTH{1'b0}}, s_value};
    assign value_in  = value_ext[VALUE_WIDTH-1:0];
    assign neg_in    = s_is_signed & value_in[VALUE_WIDTH-1];
    assign mag_in    = neg_in ? (~value_in + VALUE_WIDTH'(1)) : value_in;

    // chain of digit cells, cell 0 least significant
    assign conv_chain[0].valid = (state_reg == rict_pkg::ST_FEED);
    assign conv_chain[0].carry = mag_reg[VALUE_WIDTH-1];
    assign rd_chain[0].digit   = '0;
    assign rd_chain[0].sig     = 1'b0;

    for (genvar i = 0; i < VALUE_WIDTH; i++) begin : g_cell
        rict_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .clear    (clear),
            .shift    (shift),
            .radix    (radix_eff),
            .conv_in  (conv_chain[i]),
            .conv_out (conv_chain[i+1]),
            .rd_in    (rd_chain[i]),
            .rd_out   (rd_chain[i+1])
        );
    end

    // last bit has just left the top cell
    assign conv_done = conv_chain[VALUE_WIDTH].valid & ~conv_chain[VALUE_WIDTH-1].valid;
    assign emit      = rd_chain[VALUE_WIDTH].sig || (rd_cnt_reg == '0);
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == rict_pkg::ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        feed_cnt_next = feed_cnt_reg;
        rd_cnt_next   = rd_cnt_reg;
        clear         = 1'b0;
        shift         = 1'b0;
        load          = 1'b0;
        out_last      = 1'b0;
        out_char      = rict_pkg::digit_char(chars_low_reg, chars_high_reg,
                                             rd_chain[VALUE_WIDTH].digit);
        unique case (state_reg)
            rict_pkg::ST_IDLE: begin
                if (s_valid) begin
                    clear         = 1'b1;
                    mag_next      = mag_in;
                    neg_next      = neg_in;
                    feed_cnt_next = '0;
                    state_next    = rict_pkg::ST_FEED;
                end
            end
            rict_pkg::ST_FEED: begin
                mag_next      = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                feed_cnt_next = feed_cnt_reg + CW'(1);
                if (feed_cnt_reg == CW'(VALUE_WIDTH - 1)) begin
                    state_next = rict_pkg::ST_WAIT;
                end
            end
            rict_pkg::ST_WAIT: begin
                if (conv_done) begin
                    rd_cnt_next = CW'(VALUE_WIDTH - 1);
                    state_next  = rict_pkg::ST_READ;
                end
            end
            rict_pkg::ST_READ: begin
                if (neg_reg) begin
                    if (slot_free) begin
                        load     = 1'b1;
                        out_char = rict_pkg::MINUS_CHAR;
                        neg_next = 1'b0;
                    end
                end else if (emit) begin
                    if (slot_free) begin
                        load     = 1'b1;
                        out_last = (rd_cnt_reg == '0);
                        if (rd_cnt_reg == '0) begin
                            state_next = rict_pkg::ST_IDLE;
                        end else begin
                            shift       = 1'b1;
                            rd_cnt_next = rd_cnt_reg - CW'(1);
                        end
                    end
                end else begin
                    // leading zero, dropped
                    shift       = 1'b1;
                    rd_cnt_next = rd_cnt_reg - CW'(1);
                end
            end
            default: state_next = rict_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rict_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        feed_cnt_reg <= feed_cnt_next;
        rd_cnt_reg   <= rd_cnt_next;
        if (load) begin
            m_character_reg <= out_char;
            m_last_reg      <= out_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;

endmodule

/* rtl/rict_cell.sv */
module rict_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           clear,
    input  logic                           shift,
    input  logic [rict_pkg::RADIX_W-1:0]   radix,
    input  rict_pkg::conv_link_t           conv_in,
    output rict_pkg::conv_link_t           conv_out,
    input  rict_pkg::rd_link_t             rd_in,
    output rict_pkg::rd_link_t             rd_out
);

    logic [rict_pkg::DIGIT_W-1:0] digit_reg;
    logic [rict_pkg::DIGIT_W-1:0] digit_next;
    logic                         sig_reg;
    logic                         sig_next;
    logic                         valid_reg;
    logic                         carry_reg;
    logic                         carry_next;
    logic [rict_pkg::RADIX_W-1:0] dbl;

    // digit times two plus incoming bit, folded back below the radix
    always_comb begin
        dbl        = {digit_reg, conv_in.carry};
        carry_next = (dbl >= radix);
        digit_next = digit_reg;
        sig_next   = sig_reg;
        if (clear) begin
            digit_next = '0;
            sig_next   = 1'b0;
        end else if (shift) begin
            digit_next = rd_in.digit;
            sig_next   = rd_in.sig;
        end else if (conv_in.valid) begin
            if (carry_next) begin
                digit_next = rict_pkg::DIGIT_W'(dbl - radix);
            end else begin
                digit_next = dbl[rict_pkg::DIGIT_W-1:0];
            end
            // once a carry reaches this place the number has a digit here
            sig_next = sig_reg | conv_in.carry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= conv_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        carry_reg <= conv_in.valid & carry_next;
        digit_reg <= digit_next;
        sig_reg   <= sig_next;
    end

    assign conv_out.valid = valid_reg;
    assign conv_out.carry = carry_reg;
    assign rd_out.digit   = digit_reg;
    assign rd_out.sig     = sig_reg;

endmodule

/* dv/radix_integer_to_ascii_test.sv */
module radix_integer_to_ascii_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 120;

    typedef struct packed {
        logic [rict_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } text_char_t;

    class text_scoreboard;
        text_char_t                   expected_text[$];
        logic [rict_pkg::RADIX_W-1:0] radix;
        logic [rict_pkg::CFG_W-1:0]   glyphs_low;
        logic [rict_pkg::CFG_W-1:0]   glyphs_high;
        int                           errors;

        function new();
            radix       = rict_pkg::RADIX_RESET;
            glyphs_low  = rict_pkg::CHARS_LOW_RESET;
            glyphs_high = rict_pkg::CHARS_HIGH_RESET;
            errors      = 0;
        endfunction

        function void set_reg(rict_pkg::reg_index_t idx, logic [rict_pkg::CFG_W-1:0] data);
            case (idx)
                rict_pkg::REG_RADIX:      radix = data[rict_pkg::RADIX_W-1:0];
                rict_pkg::REG_CHARS_LOW:  glyphs_low = data;
                rict_pkg::REG_CHARS_HIGH: glyphs_high = data;
                default: ;
            endcase
        endfunction

        function logic [rict_pkg::CHAR_W-1:0] glyph_of(logic [rict_pkg::DIGIT_W-1:0] d);
            logic [2*rict_pkg::CFG_W-1:0] all_glyphs;
            all_glyphs = {glyphs_high, glyphs_low};
            return all_glyphs[8*d +: rict_pkg::CHAR_W];
        endfunction

        // accepted number: queue its text, sign first, then digits msd first
        function void add_number(logic [31:0] value, logic sgn);
            logic [31:0]                  mag;
            logic [rict_pkg::RADIX_W-1:0] base;
            logic [rict_pkg::DIGIT_W-1:0] digits[$];
            logic                         neg;
            text_char_t                   tc;
            neg  = sgn && value[31];
            base = radix;
            if (base < rict_pkg::RADIX_MIN) base = rict_pkg::RADIX_MIN;
            if (base > rict_pkg::RADIX_MAX) base = rict_pkg::RADIX_MAX;
            mag = neg ? (32'h0 - value) : value;
            do begin
                digits.push_front(rict_pkg::DIGIT_W'(mag % base));
                mag = mag / base;
            end while (mag != 0);
            if (neg) begin
                tc.ch   = rict_pkg::MINUS_CHAR;
                tc.last = 1'b0;
                expected_text.push_back(tc);
            end
            foreach (digits[i]) begin
                tc.ch   = glyph_of(digits[i]);
                tc.last = (i == digits.size() - 1);
                expected_text.push_back(tc);
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_char(logic [rict_pkg::CHAR_W-1:0] ch, logic last);
            text_char_t want;
            if (expected_text.size() == 0) begin
                report($sformatf("unexpected char 0x%02h last %0b", ch, last));
            end else begin
                want = expected_text.pop_front();
                if (ch !== want.ch)
                    report($sformatf("char 0x%02h, want 0x%02h", ch, want.ch));
                if (last !== want.last)
                    report($sformatf("last %0b, want %0b", last, want.last));
            end
        endtask
    endclass

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        cfg_we;
    rict_pkg::reg_index_t        cfg_index;
    logic [rict_pkg::CFG_W-1:0]  cfg_data;
    logic                        s_valid;
    logic                        s_ready;
    logic [31:0]                 s_value;
    logic                        s_is_signed;
    logic                        m_valid;
    logic                        m_ready;
    logic [rict_pkg::CHAR_W-1:0] m_character;
    logic                        m_last;

    text_scoreboard sb;
    bit             calm;
    bit             hold_off_req;
    int             cycles;

    radix_integer_to_ascii u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_is_signed (s_is_signed),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("radix_integer_to_ascii_test: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_char(m_character, m_last);
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (!aresetn || calm) begin
                m_ready <= aresetn;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 12) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(rict_pkg::reg_index_t idx, logic [rict_pkg::CFG_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        sb.set_reg(idx, data);
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_number(logic [31:0] value, logic sgn);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 12);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_value     <= value;
        s_is_signed <= sgn;
        do @(posedge aclk); while (!s_ready);
        sb.add_number(value, sgn);
    endtask

    // lower valid and wait until every queued character has come back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_text.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 40);
            1: return 32'h0 - $urandom_range(1, 40);
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            3: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int radices[8];
        logic [rict_pkg::CFG_W-1:0] word;
        radices      = '{2, 16, 0, 31, 7, 1, 17, 10};
        sb           = new();
        calm         = 1'b0;
        hold_off_req = 1'b0;
        cycles       = 0;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = rict_pkg::REG_RADIX;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_value      = '0;
        s_is_signed  = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: decimal with the default digit set
        send_number(32'h0, 1'b0);
        send_number(32'h0, 1'b1);
        send_number(32'hFFFF_FFFF, 1'b0);
        send_number(32'hFFFF_FFFF, 1'b1);
        send_number(32'h8000_0000, 1'b1);
        send_number(32'h8000_0000, 1'b0);
        send_number(32'h7FFF_FFFF, 1'b1);
        send_number(32'd9, 1'b0);
        send_number(32'd10, 1'b0);
        drain();

        // binary, longest text
        write_reg(rict_pkg::REG_RADIX, 64'd2);
        write_reg(rict_pkg::REG_CHARS_LOW, 64'h0123_4567_89AB_CDEF);
        end_writes();
        send_number(32'h0, 1'b1);
        send_number(32'h8000_0000, 1'b1);
        send_number(32'hFFFF_FFFF, 1'b0);
        send_number(32'd5, 1'b0);
        drain();

        write_reg(rict_pkg::REG_RADIX, 64'd16);
        write_reg(rict_pkg::REG_CHARS_HIGH, 64'hFEDC_BA98_7654_3210);
        end_writes();
        send_number(32'hFFFF_FFFF, 1'b0);
        send_number(32'h8000_0000, 1'b1);
        send_number(32'hFEDC_BA98, 1'b0);
        send_number(32'h0, 1'b0);
        drain();

        // radix saturation at both ends
        write_reg(rict_pkg::REG_RADIX, 64'd0);
        end_writes();
        send_number(32'd6, 1'b0);
        drain();
        write_reg(rict_pkg::REG_RADIX, 64'd31);
        end_writes();
        send_number(32'hDEAD_BEEF, 1'b1);
        drain();
        write_reg(rict_pkg::REG_RADIX, 64'd17);
        end_writes();
        send_number(32'd255, 1'b0);
        drain();

        foreach (radices[p]) begin
            word = {$urandom, $urandom};
            word[rict_pkg::RADIX_W-1:0] = rict_pkg::RADIX_W'(radices[p]);
            write_reg(rict_pkg::REG_RADIX, word);
            write_reg(rict_pkg::REG_CHARS_LOW, {$urandom, $urandom});
            write_reg(rict_pkg::REG_CHARS_HIGH, {$urandom, $urandom});
            end_writes();
            if (p == 1) hold_off_req = 1'b1;
            if (p == 7) calm = 1'b1;
            repeat (26) send_number(pick_value(), 1'($urandom_range(0, 1)));
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("radix_integer_to_ascii_test: PASS");
        else
            $display("radix_integer_to_ascii_test: FAIL");
        $finish;
    end

endmodule
